// ===== hdl/kdsa_pkg.sv =====
// ----------------------------------------------------------------------------
// kdsa_pkg
// Shared types, constants and helper functions of the doorbell slot allocator.
// ----------------------------------------------------------------------------
package kdsa_pkg;

    // Number of doorbell slots. The design works for any value from 2 to 1024.
    localparam int SLOTS    = 1024;
    localparam int BIT_W    = 5;
    localparam int WORD_W   = 1 << BIT_W;
    localparam int NWORDS   = (SLOTS + WORD_W - 1) / WORD_W;
    localparam int WIDX_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int SLOT_W   = WIDX_W + BIT_W;
    // Wide enough for any slot times two, and for the release slot compare
    localparam int PROD_W   = 13;

    localparam int REL_W    = 11;
    localparam int PAGE_W   = 11;
    localparam int BAR_W    = 25;
    localparam int BASE_W   = 24;
    localparam int DBDW_W   = 2;
    localparam int CFG_W    = 24;
    localparam int IN_DW    = 16;
    localparam int OUT_DW   = 40;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_ALLOCATED  = 2'd0,
        ST_FULL       = 2'd1,
        ST_RELEASED   = 2'd2,
        ST_BAD_OFFSET = 2'd3
    } t_status;

    typedef enum logic {
        CFG_DOORBELL_DWORDS = 1'b0,
        CFG_BASE_DW_OFFSET  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              en;
        logic [WIDX_W-1:0] widx;
        logic              full;
    } t_sum_upd;

    typedef struct packed {
        logic              en;
        logic [WIDX_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } t_mem_wr;

    // Bits of a bitmap word that lie beyond the last slot; they count as used.
    function automatic logic [WORD_W-1:0] pad_mask(input logic [WIDX_W-1:0] widx);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int b = 0; b < WORD_W; b++) begin
            m[b] = ((int'(widx) * WORD_W + b) >= SLOTS);
        end
        return m;
    endfunction

    // Index of the lowest clear bit of a bitmap word.
    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (!w[b]) begin
                idx = BIT_W'(b);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hdl/kernel_doorbell_slot_allocator_core.sv =====
// ----------------------------------------------------------------------------
// kernel_doorbell_slot_allocator_core
// Allocates and releases kernel doorbell slots out of a bitmap memory.
// ----------------------------------------------------------------------------
// channel  | direction | tdata                                  | tuser
// s_axis   | in        | [10:0] release_dw_offset               | [0] opcode
// m_axis   | out       | [10:0] page_dw_offset, [35:11] bar_dw  | [1:0] status
// cfg      | in        | write enable, index, data              | -
//
// A request that touches the bitmap passes through accept, memory read,
// modify and write back, and output load; one that is answered from the
// summary flags alone (full, bad offset) goes from accept straight to output
// load. The read of the word memory is registered. Reset is synchronous
// and leaves every slot free at once. A stalled result waits in the output
// register while the next request proceeds; that request then holds in its
// output state until the output register is free.
// ----------------------------------------------------------------------------
module kernel_doorbell_slot_allocator_core
    import kdsa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [IN_DW-1:0]  i_s_axis_tdata,   // [10:0] release_dw_offset
    input  logic [0:0]        i_s_axis_tuser,   // [0] opcode
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [OUT_DW-1:0] o_m_axis_tdata,   // [10:0] page_dw_offset, [35:11] bar_dw_offset
    output logic [1:0]        o_m_axis_tuser,   // [1:0] status
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_MOD  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [DBDW_W-1:0] r_db;
    logic [BASE_W-1:0] r_base;

    t_opcode           r_op;
    logic [WIDX_W-1:0] r_widx;
    logic [BIT_W-1:0]  r_bit;
    t_status           r_res_status;
    logic [PAGE_W-1:0] r_res_page;
    logic [BAR_W-1:0]  r_res_bar;

    logic              r_ovalid;
    t_status           r_ostatus;
    logic [PAGE_W-1:0] r_opage;
    logic [BAR_W-1:0]  r_obar;

    logic              sum_free;
    logic [WIDX_W-1:0] sum_widx;
    t_sum_upd          sum_upd;
    t_mem_wr           mem_wr;
    logic              mem_rd_en;
    logic [WORD_W-1:0] rd_word;

    logic              s_acc;
    logic              size2;
    t_opcode           in_op;
    logic [REL_W-1:0]  rel;
    logic [PROD_W-1:0] rel_slot;
    logic              rel_bad;

    logic [WORD_W-1:0] pad;
    logic [WORD_W-1:0] seen;
    logic [BIT_W-1:0]  alloc_bit;
    logic [WORD_W-1:0] new_word;
    logic [PROD_W-1:0] prod;
    logic              out_load;

    kdsa_summary u_summary (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (sum_upd),
        .o_free  (sum_free),
        .o_widx  (sum_widx)
    );

    kdsa_word_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_widx),
        .o_rd_data (rd_word),
        .i_wr      (mem_wr)
    );

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_db   <= DBDW_W'(2);
            r_base <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DOORBELL_DWORDS: r_db   <= i_cfg_data[DBDW_W-1:0];
                CFG_BASE_DW_OFFSET:  r_base <= i_cfg_data[BASE_W-1:0];
                default:             r_base <= r_base;
            endcase
        end
    end

    assign size2 = (r_db != DBDW_W'(1));

    // Request decode
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc    = i_s_axis_tvalid & o_s_axis_tready;
    assign in_op    = t_opcode'(i_s_axis_tuser[0]);
    assign rel      = i_s_axis_tdata[REL_W-1:0];
    assign rel_slot = size2 ? PROD_W'(rel[REL_W-1:1]) : PROD_W'(rel);
    assign rel_bad  = (rel_slot >= PROD_W'(SLOTS));

    // Modify: pick or clear a bit of the word just read
    assign pad       = pad_mask(r_widx);
    assign seen      = rd_word | pad;
    assign alloc_bit = first_zero(seen);
    assign prod      = size2 ? (PROD_W'({r_widx, alloc_bit}) << 1)
                             : PROD_W'({r_widx, alloc_bit});

    always_comb begin
        new_word = rd_word;
        if (r_op == OP_ALLOC) begin
            new_word[alloc_bit] = 1'b1;
        end else begin
            new_word[r_bit] = 1'b0;
        end
    end

    assign mem_rd_en    = (r_state == S_RD);
    assign mem_wr.en    = (r_state == S_MOD);
    assign mem_wr.addr  = r_widx;
    assign mem_wr.data  = new_word;
    assign sum_upd.en   = (r_state == S_MOD);
    assign sum_upd.widx = r_widx;
    assign sum_upd.full = &(new_word | pad);

    assign out_load = (r_state == S_OUT) && (!r_ovalid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (in_op == OP_ALLOC) begin
                        n_state = sum_free ? S_RD : S_OUT;
                    end else begin
                        n_state = rel_bad ? S_OUT : S_RD;
                    end
                end
            end
            S_RD:    n_state = S_MOD;
            S_MOD:   n_state = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Request payload and pending result
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_op         <= in_op;
            r_bit        <= rel_slot[BIT_W-1:0];
            r_widx       <= (in_op == OP_ALLOC) ? sum_widx : rel_slot[BIT_W +: WIDX_W];
            r_res_status <= (in_op == OP_ALLOC) ? ST_FULL : ST_BAD_OFFSET;
            r_res_page   <= '0;
            r_res_bar    <= '0;
        end else if (r_state == S_MOD) begin
            if (r_op == OP_ALLOC) begin
                r_res_status <= ST_ALLOCATED;
                r_res_page   <= prod[PAGE_W-1:0];
                r_res_bar    <= BAR_W'(r_base) + BAR_W'(prod);
            end else begin
                r_res_status <= ST_RELEASED;
                r_res_page   <= '0;
                r_res_bar    <= '0;
            end
        end
        if (out_load) begin
            r_ostatus <= r_res_status;
            r_opage   <= r_res_page;
            r_obar    <= r_res_bar;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = r_ostatus;
    assign o_m_axis_tdata  = OUT_DW'({r_obar, r_opage});

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_axis_tready)
        else $error("request taken while a request is in flight");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_OUT))
        else $error("result shown without passing the output state");

    a_alloc_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && r_op == OP_ALLOC) |-> !(&seen))
        else $error("allocation chose a word with no free slot");

    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr.en |=> !mem_wr.en)
        else $error("bitmap word written twice for one request");
`endif

endmodule

// ===== hdl/kdsa_word_ram.sv =====
// ----------------------------------------------------------------------------
// kdsa_word_ram
// Bitmap word memory, one read and one write port, registered read data.
// A word that was never written reads as all free.
// ----------------------------------------------------------------------------
module kdsa_word_ram
    import kdsa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [WIDX_W-1:0] i_rd_addr,
    output logic [WORD_W-1:0] o_rd_data,
    input  t_mem_wr           i_wr
);

    logic [WORD_W-1:0] r_mem [NWORDS];
    logic [NWORDS-1:0] r_vld;
    logic [WORD_W-1:0] r_rd_data;
    logic              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== hdl/kdsa_summary.sv =====
// ----------------------------------------------------------------------------
// kdsa_summary
// One full flag per bitmap word and a search for the lowest word with room.
// ----------------------------------------------------------------------------
module kdsa_summary
    import kdsa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_sum_upd          i_upd,
    output logic              o_free,
    output logic [WIDX_W-1:0] o_widx
);

    logic [NWORDS-1:0] r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
        end else if (i_upd.en) begin
            r_full[i_upd.widx] <= i_upd.full;
        end
    end

    always_comb begin
        o_free = ~&r_full;
        o_widx = '0;
        for (int w = NWORDS - 1; w >= 0; w--) begin
            if (!r_full[w]) begin
                o_widx = WIDX_W'(w);
            end
        end
    end

endmodule
